### src/iat_pkg.sv
// Shared types, constants and helper functions of the indentation-aware tokenizer.
package iat_pkg;

  localparam int INDENT_DEPTH = 16;
  localparam int KW_MAX       = 10;
  localparam int KW_COUNT     = 15;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = $clog2(Q_DEPTH);
  localparam int Q_CW         = $clog2(Q_DEPTH + 1);

  localparam int KIND_W = 6;
  localparam int LINE_W = 20;
  localparam int COL_W  = 16;
  localparam int OFF_W  = 24;
  localparam int LEN_W  = 16;
  localparam int ERR_W  = 3;
  localparam int LVL_W  = 16;
  localparam int TOP_W  = $clog2(INDENT_DEPTH + 1);
  localparam int DCNT_W = $clog2(INDENT_DEPTH + 1);

  localparam logic [KIND_W-1:0] K_INTEGER = 6'd0;
  localparam logic [KIND_W-1:0] K_FLOAT   = 6'd1;
  localparam logic [KIND_W-1:0] K_STRING  = 6'd2;
  localparam logic [KIND_W-1:0] K_IDENT   = 6'd3;
  localparam logic [KIND_W-1:0] K_PLUS    = 6'd19;
  localparam logic [KIND_W-1:0] K_MINUS   = 6'd20;
  localparam logic [KIND_W-1:0] K_STAR    = 6'd21;
  localparam logic [KIND_W-1:0] K_SLASH   = 6'd22;
  localparam logic [KIND_W-1:0] K_LESS    = 6'd23;
  localparam logic [KIND_W-1:0] K_GREATER = 6'd24;
  localparam logic [KIND_W-1:0] K_LE      = 6'd25;
  localparam logic [KIND_W-1:0] K_GE      = 6'd26;
  localparam logic [KIND_W-1:0] K_EQEQ    = 6'd27;
  localparam logic [KIND_W-1:0] K_NE      = 6'd28;
  localparam logic [KIND_W-1:0] K_EQ      = 6'd29;
  localparam logic [KIND_W-1:0] K_AT      = 6'd30;
  localparam logic [KIND_W-1:0] K_COLON   = 6'd31;
  localparam logic [KIND_W-1:0] K_COMMA   = 6'd32;
  localparam logic [KIND_W-1:0] K_DOT     = 6'd33;
  localparam logic [KIND_W-1:0] K_ARROW   = 6'd34;
  localparam logic [KIND_W-1:0] K_LPAREN  = 6'd35;
  localparam logic [KIND_W-1:0] K_RPAREN  = 6'd36;
  localparam logic [KIND_W-1:0] K_NEWLINE = 6'd39;
  localparam logic [KIND_W-1:0] K_INDENT  = 6'd40;
  localparam logic [KIND_W-1:0] K_DEDENT  = 6'd41;
  localparam logic [KIND_W-1:0] K_EOF     = 6'd42;
  localparam logic [KIND_W-1:0] K_ERROR   = 6'd43;

  localparam logic [ERR_W-1:0] E_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] E_TAB      = 3'd1;
  localparam logic [ERR_W-1:0] E_BANG     = 3'd2;
  localparam logic [ERR_W-1:0] E_BADCHAR  = 3'd3;
  localparam logic [ERR_W-1:0] E_OPENSTR  = 3'd4;
  localparam logic [ERR_W-1:0] E_INDENT   = 3'd5;
  localparam logic [ERR_W-1:0] E_OVERFLOW = 3'd6;

  // Keyword text is right-justified: the first character sits in the top used byte.
  localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
    "def", "return", "if", "else", "kernel", "load", "store", {"program", "_id"},
    "arange", {"reduce", "_sum"}, "constant", "max", "i32", "f32", "ptr"};
  localparam logic [4:0] KW_LEN [KW_COUNT] = '{
    5'd3, 5'd6, 5'd2, 5'd4, 5'd6, 5'd4, 5'd5, 5'd10,
    5'd6, 5'd10, 5'd8, 5'd3, 5'd3, 5'd3, 5'd3};
  localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
    6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18};

  typedef logic [7:0] kwbuf_t [KW_MAX];

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [COL_W-1:0]  col;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [ERR_W-1:0]  err;
  } tok_t;

  // Everything one source byte produces: token a, then a dedent burst, then token b.
  typedef struct packed {
    tok_t              a;
    tok_t              b;
    logic [DCNT_W-1:0] dcnt;
    logic [COL_W-1:0]  dcol;
    logic [OFF_W-1:0]  doff;
    logic [LINE_W-1:0] line;
  } step_rec_t;

  function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind, input logic [COL_W-1:0] col,
                                  input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len,
                                  input logic [ERR_W-1:0] err);
    tok_t t;
    t.valid = 1'b1;
    t.kind  = kind;
    t.col   = col;
    t.off   = off;
    t.len   = len;
    t.err   = err;
    return t;
  endfunction

  function automatic logic [KIND_W-1:0] kw_kind(input kwbuf_t b, input logic [LEN_W-1:0] len);
    logic [KIND_W-1:0] k;
    logic              hit;
    k = K_IDENT;
    for (int w = 0; w < KW_COUNT; w++) begin
      hit = (len == LEN_W'(KW_LEN[w]));
      for (int i = 0; i < KW_MAX; i++) begin
        if (i < int'(KW_LEN[w])) begin
          if (b[i] != KW_TEXT[w][8*(int'(KW_LEN[w])-1-i) +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        k = KW_KIND[w];
      end
    end
    return k;
  endfunction

endpackage

### src/iat_if.sv
// Channel interfaces of the tokenizer: source bytes in, tokens out.
interface tok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;
  modport source(output valid, ch, end_of_source, input ready);
  modport sink(input valid, ch, end_of_source, output ready);
endinterface

interface tok_out_if;
  logic                         valid;
  logic                         ready;
  logic [iat_pkg::KIND_W-1:0]   token_kind;
  logic [iat_pkg::LINE_W-1:0]   line;
  logic [iat_pkg::COL_W-1:0]    column;
  logic [iat_pkg::OFF_W-1:0]    start_offset;
  logic [iat_pkg::LEN_W-1:0]    length;
  logic [iat_pkg::ERR_W-1:0]    error_code;
  logic                         last;
  modport source(output valid, token_kind, line, column, start_offset, length, error_code, last,
                 input ready);
  modport sink(input valid, token_kind, line, column, start_offset, length, error_code, last,
               output ready);
endinterface

### src/iat_front.sv
// Scanner front end: classifies each byte, tracks position and indentation, builds step records.
module iat_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_ch,
  input  logic               in_eos,
  output logic               in_ready,
  input  logic               q_full,
  output logic               push,
  output iat_pkg::step_rec_t rec
);
  import iat_pkg::*;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_NUMBER  = 3'd1;
  localparam logic [2:0] M_IDENT   = 3'd2;
  localparam logic [2:0] M_STRING  = 3'd3;
  localparam logic [2:0] M_ESCAPE  = 3'd4;
  localparam logic [2:0] M_COMMENT = 3'd5;
  localparam logic [2:0] M_OP      = 3'd6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UND   = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;
  localparam logic [OFF_W-1:0]  OFF_MAX  = '1;
  localparam logic [LVL_W-1:0]  SPC_MAX  = '1;

  logic [2:0]        mode_r, mode_nxt;
  logic              lstart_r, lstart_nxt;
  logic              nldone_r, nldone_nxt;
  logic              dot_r, dot_nxt;
  logic              squote_r, squote_nxt;
  logic [LVL_W-1:0]  space_r, space_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [COL_W-1:0]  scol_r, scol_nxt;
  logic [OFF_W-1:0]  soff_r, soff_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  logic [LVL_W-1:0]  lvl_r [1:INDENT_DEPTH-1];
  kwbuf_t            kwbuf_r;

  logic              kw_wr;
  logic [3:0]        kw_idx;
  logic              lvl_wr;
  logic              accept;
  logic              do_idle;
  logic [OFF_W-1:0]  diff;
  logic [OFF_W:0]    diff1;
  logic [LEN_W-1:0]  tl0, tl1;
  logic [INDENT_DEPTH-1:0] gt;
  logic              eq_any;
  logic [DCNT_W-1:0] pops;
  logic [KIND_W-1:0] op_kind, single;
  logic [7:0]        c;
  logic              is_dig, is_alp;

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;
  assign c        = in_ch;
  assign is_dig   = (c >= 8'h30) && (c <= 8'h39);
  assign is_alp   = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));

  // Token length from the saved start offset to the current offset.
  always_comb begin
    diff  = (off_r >= soff_r) ? (off_r - soff_r) : '0;
    diff1 = {1'b0, diff} + (OFF_W+1)'(1);
    tl0   = (diff > OFF_W'(COL_MAX)) ? '1 : diff[LEN_W-1:0];
    tl1   = (diff1 > (OFF_W+1)'(COL_MAX)) ? '1 : diff1[LEN_W-1:0];
  end

  // The stack rises strictly, so one parallel compare pass gives both pop count and match.
  always_comb begin
    gt     = '0;
    eq_any = (space_r == '0);
    for (int i = 1; i < INDENT_DEPTH; i++) begin
      if (TOP_W'(i) < top_r) begin
        gt[i] = lvl_r[i] > space_r;
        if (lvl_r[i] == space_r) begin
          eq_any = 1'b1;
        end
      end
    end
    pops = DCNT_W'($countones(gt));
  end

  always_comb begin
    case (kwbuf_r[0])
      CH_MINUS: op_kind = K_MINUS;
      CH_LT:    op_kind = K_LESS;
      CH_GT:    op_kind = K_GREATER;
      CH_EQ:    op_kind = K_EQ;
      default:  op_kind = K_ERROR;
    endcase
    case (c)
      CH_PLUS:  single = K_PLUS;
      CH_STAR:  single = K_STAR;
      CH_SLASH: single = K_SLASH;
      CH_LPAR:  single = K_LPAREN;
      CH_RPAR:  single = K_RPAREN;
      CH_AT:    single = K_AT;
      CH_COLON: single = K_COLON;
      CH_COMMA: single = K_COMMA;
      CH_DOT:   single = K_DOT;
      default:  single = K_ERROR;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    lstart_nxt = lstart_r;
    nldone_nxt = nldone_r;
    dot_nxt    = dot_r;
    squote_nxt = squote_r;
    space_nxt  = space_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    off_nxt    = off_r;
    scol_nxt   = scol_r;
    soff_nxt   = soff_r;
    top_nxt    = top_r;
    kw_wr      = 1'b0;
    kw_idx     = '0;
    lvl_wr     = 1'b0;
    do_idle    = 1'b0;
    rec        = '0;
    rec.line   = line_r;
    rec.dcol   = 16'd1;
    rec.doff   = off_r;

    if (in_eos) begin
      case (mode_r)
        M_NUMBER: rec.a = mk_tok(dot_r ? K_FLOAT : K_INTEGER, scol_r, soff_r, tl0, E_NONE);
        M_IDENT:  rec.a = mk_tok(kw_kind(kwbuf_r, tl0), scol_r, soff_r, tl0, E_NONE);
        M_OP:     rec.a = mk_tok(op_kind, scol_r, soff_r, tl0,
                                 (op_kind == K_ERROR) ? E_BANG : E_NONE);
        M_STRING, M_ESCAPE: rec.a = mk_tok(K_ERROR, scol_r, soff_r, tl0, E_OPENSTR);
        default: ;
      endcase
      rec.dcnt   = DCNT_W'(top_r - TOP_W'(1));
      rec.dcol   = col_r;
      rec.b      = mk_tok(K_EOF, col_r, off_r, '0, E_NONE);
      mode_nxt   = M_IDLE;
      lstart_nxt = 1'b1;
      nldone_nxt = 1'b0;
      dot_nxt    = 1'b0;
      squote_nxt = 1'b0;
      space_nxt  = '0;
      line_nxt   = LINE_W'(1);
      col_nxt    = COL_W'(1);
      off_nxt    = '0;
      scol_nxt   = '0;
      soff_nxt   = '0;
      top_nxt    = TOP_W'(1);
    end else begin
      case (mode_r)
        M_NUMBER: begin
          if (!is_dig && !(c == CH_DOT && !dot_r)) begin
            rec.a   = mk_tok(dot_r ? K_FLOAT : K_INTEGER, scol_r, soff_r, tl0, E_NONE);
            do_idle = 1'b1;
          end else if (!is_dig) begin
            dot_nxt = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alp || is_dig || c == CH_UND) begin
            if (tl0 < LEN_W'(KW_MAX)) begin
              kw_wr  = 1'b1;
              kw_idx = tl0[3:0];
            end
          end else begin
            rec.a   = mk_tok(kw_kind(kwbuf_r, tl0), scol_r, soff_r, tl0, E_NONE);
            do_idle = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_BSL) begin
            mode_nxt = M_ESCAPE;
          end else if (c == (squote_r ? CH_SQ : CH_DQ)) begin
            rec.a    = mk_tok(K_STRING, scol_r, soff_r, tl1, E_NONE);
            mode_nxt = M_IDLE;
          end
        end
        M_ESCAPE: mode_nxt = M_STRING;
        M_COMMENT: begin
          if (c == CH_LF) begin
            do_idle = 1'b1;
          end
        end
        M_OP: begin
          if (kwbuf_r[0] == CH_MINUS && c == CH_GT) begin
            rec.a    = mk_tok(K_ARROW, scol_r, soff_r, tl1, E_NONE);
            mode_nxt = M_IDLE;
          end else if (c == CH_EQ && kwbuf_r[0] != CH_MINUS) begin
            case (kwbuf_r[0])
              CH_LT:   rec.a = mk_tok(K_LE, scol_r, soff_r, tl1, E_NONE);
              CH_GT:   rec.a = mk_tok(K_GE, scol_r, soff_r, tl1, E_NONE);
              CH_EQ:   rec.a = mk_tok(K_EQEQ, scol_r, soff_r, tl1, E_NONE);
              default: rec.a = mk_tok(K_NE, scol_r, soff_r, tl1, E_NONE);
            endcase
            mode_nxt = M_IDLE;
          end else begin
            rec.a   = mk_tok(op_kind, scol_r, soff_r, tl0,
                             (op_kind == K_ERROR) ? E_BANG : E_NONE);
            do_idle = 1'b1;
          end
        end
        default: begin
          if (lstart_r) begin
            if (c == CH_SPACE) begin
              if (space_r < SPC_MAX) begin
                space_nxt = space_r + LVL_W'(1);
              end
            end else if (c == CH_CR || c == CH_LF) begin
              do_idle = 1'b1;
            end else if (c == CH_HASH) begin
              lstart_nxt = 1'b0;
              mode_nxt   = M_COMMENT;
            end else begin
              lstart_nxt = 1'b0;
              do_idle    = 1'b1;
              if (gt == '0 && !eq_any) begin
                if (top_r < TOP_W'(INDENT_DEPTH)) begin
                  lvl_wr  = 1'b1;
                  top_nxt = top_r + TOP_W'(1);
                  rec.a   = mk_tok(K_INDENT, 16'd1, off_r, '0, E_NONE);
                end else begin
                  rec.a = mk_tok(K_ERROR, 16'd1, off_r, '0, E_OVERFLOW);
                end
              end else if (gt != '0) begin
                top_nxt  = top_r - TOP_W'(pops);
                rec.dcnt = pops;
                if (!eq_any) begin
                  rec.a = mk_tok(K_ERROR, 16'd1, off_r, '0, E_INDENT);
                end
              end
            end
          end else begin
            do_idle = 1'b1;
          end
        end
      endcase

      if (do_idle) begin
        mode_nxt = M_IDLE;
        if (c == CH_SPACE || c == CH_CR) begin
          mode_nxt = M_IDLE;
        end else if (c == CH_HASH) begin
          mode_nxt = M_COMMENT;
        end else if (c == CH_LF) begin
          if (!nldone_r) begin
            rec.b = mk_tok(K_NEWLINE, col_r, off_r, LEN_W'(1), E_NONE);
          end
          nldone_nxt = 1'b1;
          lstart_nxt = 1'b1;
          space_nxt  = '0;
        end else if (c == CH_TAB) begin
          rec.b = mk_tok(K_ERROR, col_r, off_r, LEN_W'(1), E_TAB);
        end else begin
          nldone_nxt = 1'b0;
          scol_nxt   = col_r;
          soff_nxt   = off_r;
          if (is_dig) begin
            dot_nxt  = 1'b0;
            mode_nxt = M_NUMBER;
          end else if (is_alp || c == CH_UND) begin
            kw_wr    = 1'b1;
            kw_idx   = '0;
            mode_nxt = M_IDENT;
          end else if (c == CH_DQ || c == CH_SQ) begin
            squote_nxt = (c == CH_SQ);
            mode_nxt   = M_STRING;
          end else if (c == CH_MINUS || c == CH_LT || c == CH_GT || c == CH_EQ ||
                       c == CH_BANG) begin
            kw_wr    = 1'b1;
            kw_idx   = '0;
            mode_nxt = M_OP;
          end else begin
            rec.b = mk_tok(single, col_r, off_r, LEN_W'(1),
                           (single == K_ERROR) ? E_BADCHAR : E_NONE);
          end
        end
      end

      // Every byte advances the position exactly once.
      if (off_r < OFF_MAX) begin
        off_nxt = off_r + OFF_W'(1);
      end
      if (c == CH_LF) begin
        if (line_r < LINE_MAX) begin
          line_nxt = line_r + LINE_W'(1);
        end
        col_nxt = COL_W'(1);
      end else if (col_r < COL_MAX) begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  assign push = accept && (rec.a.valid || rec.b.valid || rec.dcnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      lstart_r <= 1'b1;
      nldone_r <= 1'b0;
      dot_r    <= 1'b0;
      squote_r <= 1'b0;
      space_r  <= '0;
      line_r   <= LINE_W'(1);
      col_r    <= COL_W'(1);
      off_r    <= '0;
      scol_r   <= '0;
      soff_r   <= '0;
      top_r    <= TOP_W'(1);
    end else if (accept) begin
      mode_r   <= mode_nxt;
      lstart_r <= lstart_nxt;
      nldone_r <= nldone_nxt;
      dot_r    <= dot_nxt;
      squote_r <= squote_nxt;
      space_r  <= space_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      off_r    <= off_nxt;
      scol_r   <= scol_nxt;
      soff_r   <= soff_nxt;
      top_r    <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kw_wr) begin
      kwbuf_r[kw_idx] <= c;
    end
    for (int i = 1; i < INDENT_DEPTH; i++) begin
      if (accept && lvl_wr && top_r == TOP_W'(i)) begin
        lvl_r[i] <= space_r;
      end
    end
  end

endmodule

### src/iat_queue.sv
// Small FIFO of step records between the scanner and the token emitter.
module iat_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  iat_pkg::step_rec_t push_rec,
  input  logic               pop,
  output iat_pkg::step_rec_t head,
  output logic               head_valid,
  output logic               full
);
  import iat_pkg::*;

  step_rec_t       q_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_CW-1:0] cnt_r;

  assign head       = q_r[rd_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == Q_CW'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_rec;
    end
  end

endmodule

### src/iat_back.sv
// Token emitter: expands each step record into tokens and drives the output register.
module iat_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  iat_pkg::step_rec_t         head,
  input  logic                       head_valid,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [iat_pkg::KIND_W-1:0] out_kind,
  output logic [iat_pkg::LINE_W-1:0] out_line,
  output logic [iat_pkg::COL_W-1:0]  out_col,
  output logic [iat_pkg::OFF_W-1:0]  out_off,
  output logic [iat_pkg::LEN_W-1:0]  out_len,
  output logic [iat_pkg::ERR_W-1:0]  out_err,
  output logic                       out_last
);
  import iat_pkg::*;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_D = 2'd1;
  localparam logic [1:0] PH_B = 2'd2;

  logic [1:0]        ph_r, ph_nxt;
  logic [DCNT_W-1:0] dleft_r, dleft_nxt;
  logic [DCNT_W-1:0] cur_d;
  logic [1:0]        sel;
  tok_t              tok;
  logic              last;
  logic              load;
  logic              out_valid_r;
  tok_t              tok_r;
  logic [LINE_W-1:0] line_r;
  logic              last_r;

  always_comb begin
    cur_d = (ph_r == PH_A) ? head.dcnt : dleft_r;
    if (ph_r == PH_A && head.a.valid) begin
      sel = PH_A;
    end else if (ph_r != PH_B && cur_d != '0) begin
      sel = PH_D;
    end else begin
      sel = PH_B;
    end
    case (sel)
      PH_A: begin
        tok  = head.a;
        last = (head.dcnt == '0) && !head.b.valid;
      end
      PH_D: begin
        tok  = mk_tok(K_DEDENT, head.dcol, head.doff, '0, E_NONE);
        last = (cur_d == DCNT_W'(1)) && !head.b.valid;
      end
      default: begin
        tok  = head.b;
        last = 1'b1;
      end
    endcase

    load      = head_valid && (!out_valid_r || out_ready);
    pop       = load && last;
    ph_nxt    = ph_r;
    dleft_nxt = dleft_r;
    if (load) begin
      if (last) begin
        ph_nxt = PH_A;
      end else begin
        case (sel)
          PH_A: begin
            dleft_nxt = head.dcnt;
            ph_nxt    = (head.dcnt != '0) ? PH_D : PH_B;
          end
          PH_D: begin
            dleft_nxt = cur_d - DCNT_W'(1);
            ph_nxt    = (cur_d != DCNT_W'(1)) ? PH_D : PH_B;
          end
          default: ph_nxt = PH_A;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_A;
      dleft_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r    <= ph_nxt;
      dleft_r <= dleft_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= tok;
      line_r <= head.line;
      last_r <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = tok_r.kind;
  assign out_line  = line_r;
  assign out_col   = tok_r.col;
  assign out_off   = tok_r.off;
  assign out_len   = tok_r.len;
  assign out_err   = tok_r.err;
  assign out_last  = last_r;

endmodule

### src/indentation_aware_tokenizer.sv
// Top level of the indentation-aware tokenizer.
//
// in_chan carries one source byte per transfer (ch), or an end marker (end_of_source = 1)
// that flushes any open token, closes every open indentation level and emits EndOfFile.
// out_chan carries tokens: kind, line, column, start offset, length, error code, and last,
// which marks the final token caused by one input transfer. Inputs that cause no token
// give no output transfer.
// The scanner takes one byte per cycle while its four-entry record queue has room; the
// emitter sends one token per cycle while the receiver is ready, each in its own transfer.
// Dedent bursts (up to fifteen tokens from one byte) are what fill the queue and hold
// in_chan.ready low. Each record passes the record queue and then the output register.
// A stalled receiver holds the output register; the queue then fills and input stops.
// Reset (synchronous, active low) empties the queue and returns the scanner to line one,
// column one, offset zero with the base indentation level. After an end marker the
// scanner returns to that same state by itself for the next source.
module indentation_aware_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  tok_in_if.sink    in_chan,
  tok_out_if.source out_chan
);
  import iat_pkg::*;

  step_rec_t push_rec, head;
  logic      push, pop, head_valid, q_full;

  iat_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ch    (in_chan.ch),
    .in_eos   (in_chan.end_of_source),
    .in_ready (in_chan.ready),
    .q_full   (q_full),
    .push     (push),
    .rec      (push_rec)
  );

  iat_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  iat_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_kind   (out_chan.token_kind),
    .out_line   (out_chan.line),
    .out_col    (out_chan.column),
    .out_off    (out_chan.start_offset),
    .out_len    (out_chan.length),
    .out_err    (out_chan.error_code),
    .out_last   (out_chan.last)
  );

endmodule

### bench/tokenizer_checker.sv
// Token predictor and scoreboard that watches the tokenizer's byte and token channels.
`timescale 1ns / 100ps
module tokenizer_checker (
  input  logic clk,
  input  logic rst_n,
  tok_in_if    in_mon,
  tok_out_if   out_mon,
  output int   mismatches,
  output int   outstanding
);
  import iat_pkg::*;

  typedef enum {SC_IDLE, SC_NUMBER, SC_WORD, SC_STRING, SC_ESCAPE, SC_COMMENT, SC_OP} scan_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [ERR_W-1:0]  err;
    logic              last;
  } token_rec_t;

  localparam int STEP_MAX = 18;

  string kw_words [15] = '{"def", "return", "if", "else", "kernel", "load", "store",
                            {"program", "_id"}, "arange", {"reduce", "_sum"}, "constant",
                            "max", "i32", "f32", "ptr"};

  logic [LVL_W-1:0]  levels [INDENT_DEPTH];
  int                depth;
  logic [LINE_W-1:0] line_no;
  logic [COL_W-1:0]  col_no;
  logic [OFF_W-1:0]  offset;
  scan_e             mode;
  logic [COL_W-1:0]  tok_col;
  logic [OFF_W-1:0]  tok_off;
  logic [7:0]        word_buf [KW_MAX];
  bit                at_line_start, newline_done, dot_seen, single_quote;
  logic [15:0]       spaces;

  token_rec_t step_toks[$];
  token_rec_t expected_toks[$];

  function automatic void clear_scanner();
    foreach (levels[i]) levels[i] = '0;
    foreach (word_buf[i]) word_buf[i] = '0;
    depth = 1;
    line_no = 1;
    col_no = 1;
    offset = 0;
    mode = SC_IDLE;
    tok_col = 0;
    tok_off = 0;
    at_line_start = 1;
    newline_done = 0;
    dot_seen = 0;
    single_quote = 0;
    spaces = 0;
  endfunction

  function automatic void put_tok(input logic [KIND_W-1:0] kind, input logic [COL_W-1:0] c,
                                  input logic [OFF_W-1:0] o, input int len,
                                  input logic [ERR_W-1:0] err);
    token_rec_t t;
    if (step_toks.size() >= STEP_MAX) return;
    t = '{kind, line_no, c, o, len[LEN_W-1:0], err, 1'b0};
    step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic void step_pos(input logic [7:0] c);
    if (offset != '1) offset++;
    if (c == 8'h0A) begin
      if (line_no != '1) line_no++;
      col_no = 1;
    end else if (col_no != '1) begin
      col_no++;
    end
  endfunction

  function automatic int span_len(input int extra);
    int d;
    d = (offset >= tok_off) ? int'(offset - tok_off) : 0;
    d += extra;
    return (d > 16'hFFFF) ? 16'hFFFF : d;
  endfunction

  function automatic void put_open(input logic [KIND_W-1:0] kind, input int extra,
                                   input logic [ERR_W-1:0] err);
    put_tok(kind, tok_col, tok_off, span_len(extra), err);
  endfunction

  function automatic void finish_word();
    int len;
    logic [KIND_W-1:0] kind;
    bit hit;
    len = span_len(0);
    kind = K_IDENT;
    if (len <= KW_MAX) begin
      for (int w = 0; w < 15; w++) begin
        if (kw_words[w].len() == len && kind == K_IDENT) begin
          hit = 1;
          for (int j = 0; j < len; j++) begin
            if (word_buf[j] != kw_words[w][j]) hit = 0;
          end
          if (hit) kind = KIND_W'(4 + w);
        end
      end
    end
    put_open(kind, 0, E_NONE);
  endfunction

  function automatic void finish_op();
    case (word_buf[0])
      "-": put_open(K_MINUS, 0, E_NONE);
      "<": put_open(K_LESS, 0, E_NONE);
      ">": put_open(K_GREATER, 0, E_NONE);
      "=": put_open(K_EQ, 0, E_NONE);
      default: put_open(K_ERROR, 0, E_BANG);
    endcase
  endfunction

  function automatic void close_tokens();
    case (mode)
      SC_NUMBER: put_open(dot_seen ? K_FLOAT : K_INTEGER, 0, E_NONE);
      SC_WORD: finish_word();
      SC_OP: finish_op();
      SC_STRING, SC_ESCAPE: put_open(K_ERROR, 0, E_OPENSTR);
      default: ;
    endcase
  endfunction

  function automatic void resolve_indent();
    int n, popped;
    n = spaces;
    if (n > levels[depth-1]) begin
      if (depth < INDENT_DEPTH) begin
        levels[depth] = LVL_W'(n);
        depth++;
        put_tok(K_INDENT, 1, offset, 0, E_NONE);
      end else begin
        put_tok(K_ERROR, 1, offset, 0, E_OVERFLOW);
      end
    end else if (n < levels[depth-1]) begin
      popped = 0;
      while (depth > 1 && levels[depth-1] > n) begin
        depth--;
        popped++;
      end
      if (levels[depth-1] != n) put_tok(K_ERROR, 1, offset, 0, E_INDENT);
      repeat (popped) put_tok(K_DEDENT, 1, offset, 0, E_NONE);
    end
    at_line_start = 0;
  endfunction

  function automatic void scan_fresh(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    if (c == " " || c == 8'h0D) begin
      step_pos(c);
      return;
    end
    if (c == "#") begin
      mode = SC_COMMENT;
      step_pos(c);
      return;
    end
    if (c == 8'h0A) begin
      if (!newline_done) put_tok(K_NEWLINE, col_no, offset, 1, E_NONE);
      newline_done = 1;
      at_line_start = 1;
      spaces = 0;
      step_pos(c);
      return;
    end
    if (c == 8'h09) begin
      put_tok(K_ERROR, col_no, offset, 1, E_TAB);
      step_pos(c);
      return;
    end
    newline_done = 0;
    tok_col = col_no;
    tok_off = offset;
    if (c >= "0" && c <= "9") begin
      dot_seen = 0;
      mode = SC_NUMBER;
    end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
      word_buf[0] = c;
      mode = SC_WORD;
    end else if (c == 8'h22 || c == 8'h27) begin
      single_quote = (c == 8'h27);
      mode = SC_STRING;
    end else if (c == "-" || c == "<" || c == ">" || c == "=" || c == "!") begin
      word_buf[0] = c;
      mode = SC_OP;
    end else begin
      case (c)
        "+": k = K_PLUS;
        "*": k = K_STAR;
        "/": k = K_SLASH;
        "(": k = K_LPAREN;
        ")": k = K_RPAREN;
        "@": k = K_AT;
        ":": k = K_COLON;
        ",": k = K_COMMA;
        ".": k = K_DOT;
        default: k = K_ERROR;
      endcase
      put_open(k, 1, (k == K_ERROR) ? E_BADCHAR : E_NONE);
    end
    step_pos(c);
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    bit is_dig, is_word;
    logic [KIND_W-1:0] k;
    int i;
    is_dig = (c >= "0" && c <= "9");
    is_word = is_dig || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    case (mode)
      SC_NUMBER: begin
        if (is_dig) begin step_pos(c); return; end
        if (c == "." && !dot_seen) begin dot_seen = 1; step_pos(c); return; end
        put_open(dot_seen ? K_FLOAT : K_INTEGER, 0, E_NONE);
      end
      SC_WORD: begin
        if (is_word) begin
          i = span_len(0);
          if (i < KW_MAX) word_buf[i] = c;
          step_pos(c);
          return;
        end
        finish_word();
      end
      SC_STRING: begin
        if (c == "\\") begin
          mode = SC_ESCAPE;
        end else if (c == (single_quote ? 8'h27 : 8'h22)) begin
          put_open(K_STRING, 1, E_NONE);
          mode = SC_IDLE;
        end
        step_pos(c);
        return;
      end
      SC_ESCAPE: begin
        mode = SC_STRING;
        step_pos(c);
        return;
      end
      SC_COMMENT: begin
        if (c != 8'h0A) begin step_pos(c); return; end
      end
      SC_OP: begin
        k = '0;
        if (word_buf[0] == "-" && c == ">") k = K_ARROW;
        else if (c == "=") begin
          case (word_buf[0])
            "<": k = K_LE;
            ">": k = K_GE;
            "=": k = K_EQEQ;
            "!": k = K_NE;
            default: ;
          endcase
        end
        if (k != '0) begin
          put_open(k, 1, E_NONE);
          mode = SC_IDLE;
          step_pos(c);
          return;
        end
        finish_op();
      end
      default: begin
        if (at_line_start) begin
          if (c == " ") begin
            if (spaces != 16'hFFFF) spaces++;
            step_pos(c);
            return;
          end
          if (c == 8'h0D || c == 8'h0A) begin scan_fresh(c); return; end
          if (c == "#") begin
            at_line_start = 0;
            mode = SC_COMMENT;
            step_pos(c);
            return;
          end
          resolve_indent();
        end
      end
    endcase
    mode = SC_IDLE;
    scan_fresh(c);
  endfunction

  task automatic report(input string what, input longint exp_v, input longint got_v);
    $display("%0t: token mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v,
             got_v);
    mismatches++;
  endtask

  initial begin
    clear_scanner();
  end

  always @(posedge clk) begin
    token_rec_t e, g;
    if (!rst_n) begin
      clear_scanner();
      expected_toks.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        g = '{out_mon.token_kind, out_mon.line, out_mon.column, out_mon.start_offset,
              out_mon.length, out_mon.error_code, out_mon.last};
        if (expected_toks.size() == 0) begin
          report("unexpected token kind", -1, g.kind);
        end else begin
          e = expected_toks.pop_front();
          if (g.kind != e.kind) report("token_kind", e.kind, g.kind);
          if (g.line != e.line) report("line", e.line, g.line);
          if (g.col  != e.col)  report("column", e.col, g.col);
          if (g.off  != e.off)  report("start_offset", e.off, g.off);
          if (g.len  != e.len)  report("length", e.len, g.len);
          if (g.err  != e.err)  report("error_code", e.err, g.err);
          if (g.last != e.last) report("last", e.last, g.last);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        step_toks.delete();
        if (in_mon.end_of_source) begin
          close_tokens();
          for (int d = 1; d < depth; d++) put_tok(K_DEDENT, col_no, offset, 0, E_NONE);
          put_tok(K_EOF, col_no, offset, 0, E_NONE);
          clear_scanner();
        end else begin
          scan_char(in_mon.ch);
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1;
        foreach (step_toks[i]) expected_toks.insert(expected_toks.size(), step_toks[i]);
      end
    end
    outstanding = expected_toks.size();
  end

endmodule

### bench/tb.sv
// Testbench top: drives source text into the tokenizer and gives the verdict.
`timescale 1ns / 100ps
module tb;
  import iat_pkg::*;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   gap_pct;
  int   stall_pct;
  logic [7:0] src_q[$];
  int   widths[$];

  tok_in_if  in_chan();
  tok_out_if out_chan();

  indentation_aware_tokenizer uut (.clk(clk), .rst_n(rst_n), .in_chan(in_chan),
                                   .out_chan(out_chan));

  tokenizer_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
                         .mismatches(mismatches), .outstanding(outstanding));

  string kw_pick [16] = '{"def", "return", "if", "else", "kernel", "load", "store",
                          {"program", "_id"}, "arange", {"reduce", "_sum"}, "constant", "max",
                          "i32", "f32", "ptr", {"program", "_ids"}};
  string op_pick [19] = '{"+", "-", "*", "/", "<", ">", "<=", ">=", "==", "!=", "=", "@",
                          ":", ",", ".", "->", "(", ")", "!"};

  initial clk = 0;
  always #10 clk = ~clk;

  always @(posedge clk) out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic add_byte(input logic [7:0] b);
    src_q.insert(src_q.size(), b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic send(input logic [7:0] b, input bit eos);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.ch            <= b;
    in_chan.end_of_source <= eos;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Sends the queued text followed by the end marker; ch carries noise on the marker.
  task automatic run_source();
    foreach (src_q[i]) send(src_q[i], 1'b0);
    send(8'($urandom), 1'b1);
    src_q.delete();
  endtask

  task automatic rand_token();
    int n;
    case ($urandom_range(0, 13))
      0, 1: put_str(kw_pick[$urandom_range(0, 15)]);
      2, 3: begin
        n = $urandom_range(1, 13);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: add_byte(8'($urandom_range("a", "z")));
            1: add_byte(8'($urandom_range("A", "Z")));
            2: add_byte((i == 0) ? "_" : 8'($urandom_range("0", "9")));
            default: add_byte("_");
          endcase
        end
      end
      4: put_str($sformatf("%0d", $urandom_range(0, 99999)));
      5: put_str($sformatf("%0d.%0d%s", $urandom_range(0, 99), $urandom_range(0, 9),
                           $urandom_range(0, 2) == 0 ? ".5" : ""));
      6: begin
        add_byte($urandom_range(0, 1) ? 8'h22 : 8'h27);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 5))
            0: put_str("\\");
            1: add_byte($urandom_range(0, 1) ? 8'h22 : 8'h27);
            2: add_byte(8'h0A);
            default: add_byte(8'($urandom_range("a", "z")));
          endcase
        end
        add_byte($urandom_range(0, 1) ? 8'h22 : 8'h27);
      end
      7, 8, 9: put_str(op_pick[$urandom_range(0, 18)]);
      10: add_byte(8'h09);
      11: put_str("# note");
      12: add_byte(8'h0D);
      default: add_byte(8'($urandom));
    endcase
  endtask

  // Builds and sends one random source: mostly well-formed indented lines with random content.
  task automatic rand_source(input int nlines);
    int w, k;
    widths = '{0};
    for (int l = 0; l < nlines; l++) begin
      w = widths[widths.size()-1];
      case ($urandom_range(0, 9))
        4, 5: begin
          w = w + $urandom_range(1, 4);
          widths.insert(widths.size(), w);
        end
        6, 7: begin
          k = $urandom_range(0, widths.size() - 1);
          while (widths.size() > k + 1) void'(widths.pop_back());
          w = widths[k];
        end
        8: w = $urandom_range(0, 12);
        default: ;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        put_str($urandom_range(0, 1) ? "\n" : "  # only a comment\n");
        continue;
      end
      repeat (w) add_byte(" ");
      k = $urandom_range(1, 5);
      for (int t = 0; t < k; t++) begin
        rand_token();
        if ($urandom_range(0, 2) == 0) add_byte(" ");
      end
      if ($urandom_range(0, 5) == 0) add_byte(8'h0D);
      add_byte(8'h0A);
    end
    // Half the sources end without a final newline, which can leave a token open.
    if ($urandom_range(0, 1)) void'(src_q.pop_back());
    run_source();
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (outstanding != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    in_chan.valid         <= 1'b0;
    in_chan.ch            <= 8'h00;
    in_chan.end_of_source <= 1'b0;
    rst_n      <= 1'b0;
    gap_pct    = 0;
    stall_pct  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // No idling. Operators, numbers with two dots, tab, bang, high and low bytes, CR,
    // repeated newlines, then every keyword.
    put_str("x = 1.5.2 <= >= == != -> ! @:,.()+-*/<>=");
    add_byte(8'h09);
    add_byte(8'h80);
    add_byte(8'hFF);
    add_byte(8'h00);
    put_str("\r\n\n\n");
    run_source();
    put_str({"def return if else kernel load store program", "_id arange reduce", "_sum\n"});
    put_str({"constant max i32 f32 ptr program", "_ids\n"});
    run_source();

    // Sender idle most cycles. Inconsistent dedent, tab at a line start, comment lines,
    // escaped quotes, open strings and a lone bang at the end.
    gap_pct = 74;
    put_str("if a:\n    b\n  c\n# c\n");
    add_byte(8'h09);
    put_str("d 'it\\'s' \"q\"\n");
    run_source();
    put_str("\"abc\\");
    run_source();
    put_str("x 'ab\nc");
    run_source();
    put_str("a !");
    run_source();

    // Receiver stalling most cycles. Stack overflow, then a dedent burst from one byte.
    gap_pct   = 0;
    stall_pct = 74;
    for (int i = 0; i < 17; i++) begin
      repeat (i) add_byte(" ");
      put_str("a\n");
    end
    put_str("b\n");
    run_source();

    // Both sides idle now and then.
    gap_pct   = 16;
    stall_pct = 16;
    rand_source($urandom_range(3, 4));

    in_chan.valid <= 1'b0;
    stall_pct = 0;
    drain();
    repeat (20) @(posedge clk);
    if (outstanding == 0 && mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### indentation_aware_tokenizer.f
src/iat_pkg.sv
src/iat_if.sv
src/iat_front.sv
src/iat_queue.sv
src/iat_back.sv
src/indentation_aware_tokenizer.sv
bench/tokenizer_checker.sv
bench/tb.sv
